// File: sv/tpsf_pkg.sv
`default_nettype none

package tpsf_pkg;

  // Bits stored per pixel, one for each plane.
  localparam int unsigned PIX_W = 2;

  // Width of the vertical scroll distance field.
  localparam int unsigned ROWS_W = 4;

  // Configuration port: one 32-bit register at byte address 0.
  localparam int unsigned PADDR_W = 3;
  localparam logic [0:0] REG_EXT_MODE = 1'b0;

  // Command codes.
  typedef enum logic [2:0] {
    OP_DRAW         = 3'd0,
    OP_READ         = 3'd1,
    OP_BLANK        = 3'd2,
    OP_SCROLL_LEFT  = 3'd3,
    OP_SCROLL_RIGHT = 3'd4,
    OP_SCROLL_DOWN  = 3'd5,
    OP_SCROLL_UP    = 3'd6
  } op_e;

  // One command transaction.
  typedef struct packed {
    logic [2:0]        opcode;
    logic [6:0]        pixel_x;
    logic [5:0]        pixel_y;
    logic              turn_on;
    logic [PIX_W-1:0]  plane_mask;
    logic [ROWS_W-1:0] scroll_rows;
  } cmd_t;

  // One result transaction.
  typedef struct packed {
    logic             pixel_on;
    logic [PIX_W-1:0] plane_bits;
  } res_t;

endpackage

`default_nettype wire

// File: sv/two_plane_scrolling_framebuffer.sv
// Two-plane scrolling frame buffer.
//
// Commands arrive on cmd_i and are taken when start is high and busy is low.
// Each command gives exactly one result on res_o, shown for one cycle with
// res_valid_o high; the receiver cannot stall, so a result is never held.
// A new command may be started in the same cycle in which a result is shown.
// The mode register (extended_mode) sits at byte address 0 of the APB port.
//
// No-ops (empty mask on a draw, blank or scroll; off-screen draw or read;
// unused code) give their result straight from the command decode. A read
// waits in ST_READ for the registered store read. Draws sweep one store
// entry in extended mode and a 2x2 block in normal mode, blank and scrolls
// all PHYS_WIDTH*PHYS_HEIGHT entries, each sweep one store entry a cycle.
// The sweep rate is set by the single write port of the pixel store; each
// entry is read, merged with its source pixel or the fill value and written back.
//
// After reset the block clears the whole store, which keeps busy high through
// the sweep and ST_DRAIN; configuration writes are taken meanwhile.
`default_nettype none

module two_plane_scrolling_framebuffer import tpsf_pkg::*; #(
  parameter int unsigned PHYS_WIDTH    = 128,
  parameter int unsigned PHYS_HEIGHT   = 64,
  parameter int unsigned H_SCROLL_STEP = 4
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // Command channel
  input  wire logic               start,
  output logic                    busy,
  input  wire cmd_t               cmd_i,
  // Result channel
  output logic                    res_valid_o,
  output res_t                    res_o,
  // Configuration port
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [31:0]        pwdata,
  output logic      [31:0]        prdata,
  output logic                    pready
);

  localparam int unsigned XW    = $clog2(PHYS_WIDTH);
  localparam int unsigned YW    = $clog2(PHYS_HEIGHT);
  localparam int unsigned Depth = PHYS_WIDTH * PHYS_HEIGHT;
  localparam int unsigned AW    = $clog2(Depth);
  localparam int unsigned SXW   = $clog2(PHYS_WIDTH + 2 * H_SCROLL_STEP) + 2;
  localparam int unsigned SYW   = $clog2(PHYS_HEIGHT + 2 * (2 ** ROWS_W)) + 2;

  localparam logic [XW-1:0] XMax = XW'(PHYS_WIDTH - 1);
  localparam logic [YW-1:0] YMax = YW'(PHYS_HEIGHT - 1);
  localparam logic [8:0] LwExt  = 9'(PHYS_WIDTH);
  localparam logic [8:0] LwNorm = 9'(PHYS_WIDTH / 2);
  localparam logic [7:0] LhExt  = 8'(PHYS_HEIGHT);
  localparam logic [7:0] LhNorm = 8'(PHYS_HEIGHT / 2);
  localparam logic signed [SXW-1:0] PhysWidthS  = SXW'(PHYS_WIDTH);
  localparam logic signed [SYW-1:0] PhysHeightS = SYW'(PHYS_HEIGHT);
  localparam logic signed [SXW-1:0] HStepExt  = SXW'(H_SCROLL_STEP);
  localparam logic signed [SXW-1:0] HStepNorm = SXW'(2 * H_SCROLL_STEP);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_RUN   = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_READ  = 4'b1000
  } state_e;

  state_e state_q, state_d;

  // Sweep position and bounds.
  logic [XW-1:0] x_q, x_d, x_first_q, x_first_d, x_last_q, x_last_d;
  logic [YW-1:0] y_q, y_d, y_last_q, y_last_d;
  logic          x_dec_q, x_dec_d, y_dec_q, y_dec_d;

  // Per-command operands.
  logic signed [SXW-1:0] dx_q, dx_d;
  logic signed [SYW-1:0] dy_q, dy_d;
  logic                  use_src_q, use_src_d;
  logic [PIX_W-1:0]      mask_q, mask_d;
  logic [PIX_W-1:0]      fill_q, fill_d;
  logic                  init_q, init_d;

  // Write-back stage.
  logic          p1_valid_q, p1_valid_d;
  logic [AW-1:0] p1_addr_q, p1_addr_d;
  logic          p1_srcv_q, p1_srcv_d;

  // Result and mode registers.
  logic res_valid_q, res_valid_d;
  res_t res_q, res_d;
  logic ext_q;

  // Store ports.
  logic [AW-1:0]    rd_a_addr, rd_b_addr, dst_addr, pix_addr;
  logic [PIX_W-1:0] rd_a, rd_b, wdata;

  // Command decode.
  op_e                   op;
  logic [8:0]            px_full;
  logic [7:0]            py_full;
  logic [XW-1:0]         px;
  logic [YW-1:0]         py;
  logic                  in_range;
  logic                  mask_nz;
  logic signed [SXW-1:0] hmag;
  logic signed [SYW-1:0] vmag;
  logic signed [SXW-1:0] sx;
  logic signed [SYW-1:0] sy;
  logic                  srcv;
  logic                  sweep_last;

  assign op      = op_e'(cmd_i.opcode);
  assign mask_nz = (cmd_i.plane_mask != '0);
  assign px_full = ext_q ? {2'b00, cmd_i.pixel_x} : {1'b0, cmd_i.pixel_x, 1'b0};
  assign py_full = ext_q ? {2'b00, cmd_i.pixel_y} : {1'b0, cmd_i.pixel_y, 1'b0};
  assign px      = px_full[XW-1:0];
  assign py      = py_full[YW-1:0];
  assign in_range = ({2'b00, cmd_i.pixel_x} < (ext_q ? LwExt : LwNorm)) &&
                    ({2'b00, cmd_i.pixel_y} < (ext_q ? LhExt : LhNorm));
  assign pix_addr = AW'(py * PHYS_WIDTH + px);
  assign hmag     = ext_q ? HStepExt : HStepNorm;
  assign vmag     = ext_q ? SYW'(cmd_i.scroll_rows) : SYW'({cmd_i.scroll_rows, 1'b0});

  // Source pixel of the current sweep position.
  assign dst_addr  = AW'(y_q * PHYS_WIDTH + x_q);
  assign sx        = $signed(SXW'(x_q)) - dx_q;
  assign sy        = $signed(SYW'(y_q)) - dy_q;
  assign srcv      = use_src_q && !sx[SXW-1] && (sx < PhysWidthS) &&
                     !sy[SYW-1] && (sy < PhysHeightS);
  assign rd_b_addr = AW'(sy[YW-1:0] * PHYS_WIDTH + sx[XW-1:0]);
  assign sweep_last = (x_q == x_last_q) && (y_q == y_last_q);

  // Merge: keep unselected planes, take the selected ones from source or fill.
  assign wdata = (rd_a & ~mask_q) | (p1_srcv_q ? (rd_b & mask_q) : fill_q);

  tpsf_store #(
    .DEPTH (Depth)
  ) u_store (
    .clk_i     (clk_i),
    .we_i      (p1_valid_q),
    .waddr_i   (p1_addr_q),
    .wdata_i   (wdata),
    .raddr_a_i (rd_a_addr),
    .raddr_b_i (rd_b_addr),
    .rdata_a_o (rd_a),
    .rdata_b_o (rd_b)
  );

  // Command sequencer and sweep address generation.
  always_comb begin
    state_d     = state_q;
    x_d         = x_q;
    y_d         = y_q;
    x_first_d   = x_first_q;
    x_last_d    = x_last_q;
    y_last_d    = y_last_q;
    x_dec_d     = x_dec_q;
    y_dec_d     = y_dec_q;
    dx_d        = dx_q;
    dy_d        = dy_q;
    use_src_d   = use_src_q;
    mask_d      = mask_q;
    fill_d      = fill_q;
    init_d      = init_q;
    p1_valid_d  = 1'b0;
    p1_addr_d   = dst_addr;
    p1_srcv_d   = srcv;
    res_valid_d = 1'b0;
    res_d       = res_q;
    rd_a_addr   = dst_addr;

    unique case (state_q)
      ST_IDLE: begin
        rd_a_addr = pix_addr;
        if (start) begin
          // Full-screen ascending sweep unless a command says otherwise.
          x_d         = '0;
          y_d         = '0;
          x_first_d   = '0;
          x_last_d    = XMax;
          y_last_d    = YMax;
          x_dec_d     = 1'b0;
          y_dec_d     = 1'b0;
          dx_d        = '0;
          dy_d        = '0;
          use_src_d   = 1'b0;
          fill_d      = '0;
          mask_d      = cmd_i.plane_mask;
          res_valid_d = 1'b1;
          res_d       = '0;
          unique case (op)
            OP_DRAW: begin
              if (in_range && mask_nz) begin
                x_d         = px;
                x_first_d   = px;
                x_last_d    = ext_q ? px : px + XW'(1);
                y_d         = py;
                y_last_d    = ext_q ? py : py + YW'(1);
                fill_d      = cmd_i.turn_on ? cmd_i.plane_mask : '0;
                res_valid_d = 1'b0;
                state_d     = ST_RUN;
              end
            end
            OP_READ: begin
              if (in_range) begin
                res_valid_d = 1'b0;
                state_d     = ST_READ;
              end
            end
            OP_BLANK: begin
              if (mask_nz) begin
                res_valid_d = 1'b0;
                state_d     = ST_RUN;
              end
            end
            OP_SCROLL_LEFT: begin
              if (mask_nz) begin
                use_src_d   = 1'b1;
                dx_d        = -hmag;
                res_valid_d = 1'b0;
                state_d     = ST_RUN;
              end
            end
            OP_SCROLL_RIGHT: begin
              if (mask_nz) begin
                use_src_d   = 1'b1;
                dx_d        = hmag;
                x_dec_d     = 1'b1;
                x_d         = XMax;
                x_first_d   = XMax;
                x_last_d    = '0;
                res_valid_d = 1'b0;
                state_d     = ST_RUN;
              end
            end
            OP_SCROLL_DOWN: begin
              if (mask_nz) begin
                use_src_d   = 1'b1;
                dy_d        = vmag;
                y_dec_d     = 1'b1;
                y_d         = YMax;
                y_last_d    = '0;
                res_valid_d = 1'b0;
                state_d     = ST_RUN;
              end
            end
            OP_SCROLL_UP: begin
              if (mask_nz) begin
                use_src_d   = 1'b1;
                dy_d        = -vmag;
                res_valid_d = 1'b0;
                state_d     = ST_RUN;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_RUN: begin
        // Issue one entry per cycle; rows outer, columns inner.
        p1_valid_d = 1'b1;
        if (x_q == x_last_q) begin
          x_d = x_first_q;
          y_d = y_dec_q ? y_q - YW'(1) : y_q + YW'(1);
        end else begin
          x_d = x_dec_q ? x_q - XW'(1) : x_q + XW'(1);
        end
        if (sweep_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // The last entry is written back in this cycle.
        state_d = ST_IDLE;
        init_d  = 1'b0;
        if (!init_q) begin
          res_valid_d = 1'b1;
          res_d       = '0;
        end
      end
      ST_READ: begin
        state_d          = ST_IDLE;
        res_valid_d      = 1'b1;
        res_d.plane_bits = rd_a;
        res_d.pixel_on   = (mask_q != '0) && ((rd_a & mask_q) == mask_q);
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers; reset starts a clearing sweep over the whole store.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_RUN;
      x_q         <= '0;
      y_q         <= '0;
      x_first_q   <= '0;
      x_last_q    <= XMax;
      y_last_q    <= YMax;
      x_dec_q     <= 1'b0;
      y_dec_q     <= 1'b0;
      dx_q        <= '0;
      dy_q        <= '0;
      use_src_q   <= 1'b0;
      mask_q      <= {PIX_W{1'b1}};
      fill_q      <= '0;
      init_q      <= 1'b1;
      p1_valid_q  <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      x_q         <= x_d;
      y_q         <= y_d;
      x_first_q   <= x_first_d;
      x_last_q    <= x_last_d;
      y_last_q    <= y_last_d;
      x_dec_q     <= x_dec_d;
      y_dec_q     <= y_dec_d;
      dx_q        <= dx_d;
      dy_q        <= dy_d;
      use_src_q   <= use_src_d;
      mask_q      <= mask_d;
      fill_q      <= fill_d;
      init_q      <= init_d;
      p1_valid_q  <= p1_valid_d;
      res_valid_q <= res_valid_d;
    end
  end

  // Payload registers of the write-back stage and the result.
  always_ff @(posedge clk_i) begin
    p1_addr_q <= p1_addr_d;
    p1_srcv_q <= p1_srcv_d;
    res_q     <= res_d;
  end

  // Mode register, written by an APB write transaction.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ext_q <= 1'b0;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_EXT_MODE)) begin
      ext_q <= pwdata[0];
    end
  end

  assign pready      = 1'b1;
  assign prdata      = (paddr[2] == REG_EXT_MODE) ? {31'd0, ext_q} : 32'd0;
  assign busy        = (state_q != ST_IDLE);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  // A write-back only follows an entry issued by the sweep.
  a_wr_follows_issue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    p1_valid_q |-> $past(state_q == ST_RUN))
    else $error("store write without an issued sweep entry");

  // The clearing pass after reset produces no result.
  a_no_result_in_init: assert property (@(posedge clk_i) disable iff (!rst_ni)
    init_q |-> !res_valid_o)
    else $error("result shown during the reset clearing pass");

  // A result is only shown once the block is free again.
  a_result_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> (state_q == ST_IDLE))
    else $error("result shown while the block is still busy");

  // A pixel read never overlaps a write-back.
  a_read_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_READ) |-> !p1_valid_q)
    else $error("store write during a pixel read");

endmodule

`default_nettype wire

// File: sv/tpsf_store.sv
`default_nettype none

// Pixel store: one write port and two registered read ports.
module tpsf_store import tpsf_pkg::*; #(
  parameter int unsigned DEPTH = 8192
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [PIX_W-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic      [PIX_W-1:0]         rdata_a_o,
  output logic      [PIX_W-1:0]         rdata_b_o
);

  logic [PIX_W-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read ports, registered.
  always_ff @(posedge clk_i) begin
    rdata_a_o <= mem[raddr_a_i];
    rdata_b_o <= mem[raddr_b_i];
  end

endmodule

`default_nettype wire

// File: tb/sv/tb_two_plane_scrolling_framebuffer.sv
`timescale 1ns / 1ps

module tb_two_plane_scrolling_framebuffer;
  import tpsf_pkg::*;

  localparam int PW = 128;
  localparam int PH = 64;
  localparam int HSTEP = 4;
  localparam logic [2:0] OP_UNUSED = 3'd7;
  localparam int STALL_LIMIT = 40000;
  localparam int PHASES = 6;
  localparam int PHASE_ITEMS = 317;
  localparam int MAX_ERR_LINES = 50;

  typedef logic [PIX_W-1:0] frame_t [PH][PW];
  typedef struct {
    int x;
    int y;
  } spot_t;

  logic               clk_i;
  logic               rst_ni;
  logic               start;
  logic               busy;
  cmd_t               cmd_i;
  logic               res_valid_o;
  res_t               res_o;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;

  // Shadow copy of the pixel store and the mode register.
  frame_t shadow_fb;
  bit     shadow_ext;

  // Results still owed by the block, one per command, oldest first.
  res_t   pending_pixels[$];
  // Recently drawn spots, so that reads often land on set pixels.
  spot_t  recent_spots[$];

  bit gapless;
  int err_count = 0;
  int results_seen = 0;
  int cmds_sent = 0;
  int draw_count = 0;
  int read_count = 0;
  int sweep_count = 0;
  int mode_writes = 0;
  int stall_cycles = 0;

  two_plane_scrolling_framebuffer #(
    .PHYS_WIDTH   (PW),
    .PHYS_HEIGHT  (PH),
    .H_SCROLL_STEP(HSTEP)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .cmd_i      (cmd_i),
    .res_valid_o(res_valid_o),
    .res_o      (res_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  // The clock runs with a 12 ns period.
  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  task automatic flag_error(input string what);
    err_count++;
    if (err_count <= MAX_ERR_LINES) begin
      $display("ERROR at %0t: %s", $time, what);
    end
  endtask

  // Move the selected planes by (dx, dy) physical pixels; vacated bits are cleared.
  function automatic void shift_planes(input logic [PIX_W-1:0] mask, input int dx,
                                       input int dy);
    frame_t           snap;
    int               x;
    int               y;
    int               sx;
    int               sy;
    logic [PIX_W-1:0] moved;
    snap = shadow_fb;
    for (y = 0; y < PH; y++) begin
      for (x = 0; x < PW; x++) begin
        sx = x - dx;
        sy = y - dy;
        moved = '0;
        if (sx >= 0 && sx < PW && sy >= 0 && sy < PH) begin
          moved = snap[sy][sx] & mask;
        end
        shadow_fb[y][x] = (snap[y][x] & ~mask) | moved;
      end
    end
  endfunction

  // Scrolls all go through the same plane shifter.
  function automatic void shadow_planes_wrap(input logic [PIX_W-1:0] mask, input int dx,
                                             input int dy);
    shift_planes(mask, dx, dy);
  endfunction

  // Apply one command to the shadow store and return the result it must give.
  function automatic res_t exec_on_shadow(input cmd_t c);
    res_t r;
    int   scale;
    int   lw;
    int   lh;
    int   i;
    int   j;
    int   px;
    int   py;
    r = '0;
    scale = shadow_ext ? 1 : 2;
    lw = PW / scale;
    lh = PH / scale;
    case (c.opcode)
      OP_DRAW: begin
        if (c.plane_mask != '0 && int'(c.pixel_x) < lw && int'(c.pixel_y) < lh) begin
          for (j = 0; j < scale; j++) begin
            for (i = 0; i < scale; i++) begin
              px = int'(c.pixel_x) * scale + i;
              py = int'(c.pixel_y) * scale + j;
              if (px < PW && py < PH) begin
                shadow_fb[py][px] = c.turn_on ? (shadow_fb[py][px] | c.plane_mask)
                                              : (shadow_fb[py][px] & ~c.plane_mask);
              end
            end
          end
        end
      end
      OP_READ: begin
        // A read samples the top-left physical pixel of the logical block.
        if (int'(c.pixel_x) < lw && int'(c.pixel_y) < lh) begin
          r.plane_bits = shadow_fb[int'(c.pixel_y) * scale][int'(c.pixel_x) * scale];
          r.pixel_on = (c.plane_mask != '0) && ((r.plane_bits & c.plane_mask) == c.plane_mask);
        end
      end
      OP_BLANK: begin
        if (c.plane_mask != '0) begin
          for (j = 0; j < PH; j++) begin
            for (i = 0; i < PW; i++) begin
              shadow_fb[j][i] = shadow_fb[j][i] & ~c.plane_mask;
            end
          end
        end
      end
      OP_SCROLL_LEFT: begin
        if (c.plane_mask != '0) shadow_planes_wrap(c.plane_mask, -(HSTEP * scale), 0);
      end
      OP_SCROLL_RIGHT: begin
        if (c.plane_mask != '0) shadow_planes_wrap(c.plane_mask, HSTEP * scale, 0);
      end
      OP_SCROLL_DOWN: begin
        if (c.plane_mask != '0) shadow_planes_wrap(c.plane_mask, 0, int'(c.scroll_rows) * scale);
      end
      OP_SCROLL_UP: begin
        if (c.plane_mask != '0) shadow_planes_wrap(c.plane_mask, 0, -(int'(c.scroll_rows) * scale));
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  function automatic cmd_t mk_cmd(input logic [2:0] op, input int x, input int y, input bit on,
                                  input int mask, input int rows);
    cmd_t c;
    c.opcode      = op;
    c.pixel_x     = 7'(x);
    c.pixel_y     = 6'(y);
    c.turn_on     = on;
    c.plane_mask  = PIX_W'(mask);
    c.scroll_rows = ROWS_W'(rows);
    return c;
  endfunction

  // Mostly draws and reads on screen, a few sweeps, some off-screen, empty-mask and unused-code noise.
  function automatic cmd_t random_cmd();
    cmd_t  c;
    int    pick;
    int    scale;
    spot_t s;
    scale = shadow_ext ? 1 : 2;
    c.turn_on     = ($urandom_range(0, 9) < 7);
    c.plane_mask  = ($urandom_range(0, 9) == 0) ? '0 : PIX_W'($urandom_range(1, 3));
    c.scroll_rows = ROWS_W'($urandom_range(0, 15));
    c.pixel_x     = 7'($urandom_range(0, 127));
    c.pixel_y     = 6'($urandom_range(0, 63));
    pick = $urandom_range(0, 999);
    if (pick < 450) begin
      c.opcode = OP_DRAW;
    end else if (pick < 920) begin
      c.opcode = OP_READ;
    end else if (pick < 945) begin
      c.opcode = 3'($urandom_range(int'(OP_BLANK), int'(OP_SCROLL_UP)));
      c.plane_mask = PIX_W'($urandom_range(1, 3));
    end else if (pick < 985) begin
      c.opcode = 3'($urandom_range(int'(OP_BLANK), int'(OP_SCROLL_UP)));
      c.plane_mask = '0;
    end else begin
      c.opcode = OP_UNUSED;
    end
    // Nine in ten draws and reads are placed on the logical screen.
    if ((c.opcode == OP_DRAW || c.opcode == OP_READ) && $urandom_range(0, 9) != 0) begin
      if (c.opcode == OP_READ && recent_spots.size() > 0 && $urandom_range(0, 1) == 1) begin
        s = recent_spots[$urandom_range(0, recent_spots.size() - 1)];
        c.pixel_x = 7'(s.x);
        c.pixel_y = 6'(s.y);
      end else begin
        c.pixel_x = 7'($urandom_range(0, PW / scale - 1));
        c.pixel_y = 6'($urandom_range(0, PH / scale - 1));
      end
    end
    if (c.opcode == OP_DRAW) begin
      s.x = int'(c.pixel_x);
      s.y = int'(c.pixel_y);
      recent_spots.push_back(s);
      if (recent_spots.size() > 32) void'(recent_spots.pop_front());
    end
    return c;
  endfunction

  // Present one command, wait for it to be taken, and record what it must return.
  task automatic issue_cmd(input cmd_t c);
    int gap;
    gap = gapless ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    cmd_i <= c;
    do @(posedge clk_i); while (busy !== 1'b0);
    pending_pixels.push_back(exec_on_shadow(c));
    cmds_sent++;
    if (c.opcode == OP_DRAW) draw_count++;
    if (c.opcode == OP_READ) read_count++;
    if (c.opcode >= OP_BLANK && c.opcode <= OP_SCROLL_UP && c.plane_mask != '0) sweep_count++;
  endtask

  // Stop issuing and let every owed result come back.
  task automatic settle_idle();
    start <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Write the mode register over APB, then read it back.
  task automatic write_mode(input logic ext);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'({REG_EXT_MODE, 2'b00});
    pwdata  <= {31'b0, ext};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    shadow_ext = ext;
    mode_writes++;
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    if (prdata[0] !== ext) begin
      flag_error($sformatf("mode register reads %b, written %b", prdata[0], ext));
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Draw and read in normal mode, including off-screen, empty-mask and unused-code cases.
  task automatic test_pixel_ops();
    issue_cmd(mk_cmd(OP_DRAW, 0, 0, 1'b1, 3, 0));
    issue_cmd(mk_cmd(OP_READ, 0, 0, 1'b0, 3, 15));
    // Far corner of the normal screen, one plane only.
    issue_cmd(mk_cmd(OP_DRAW, 63, 31, 1'b1, 1, 0));
    issue_cmd(mk_cmd(OP_READ, 63, 31, 1'b1, 3, 0));
    // Just past the normal screen: the draw is dropped and the read gives zeros.
    issue_cmd(mk_cmd(OP_DRAW, 64, 32, 1'b1, 3, 0));
    issue_cmd(mk_cmd(OP_READ, 127, 63, 1'b0, 1, 0));
    // Clearing one plane leaves the other one set.
    issue_cmd(mk_cmd(OP_DRAW, 0, 0, 1'b0, 2, 0));
    // With an empty mask the read still reports the stored bits.
    issue_cmd(mk_cmd(OP_READ, 0, 0, 1'b0, 0, 0));
    issue_cmd(mk_cmd(OP_DRAW, 5, 5, 1'b1, 0, 0));
    issue_cmd(mk_cmd(OP_UNUSED, 127, 63, 1'b1, 3, 15));
  endtask

  // Each scroll direction and blank in normal mode, with partial, full and empty plane masks.
  task automatic test_sweeps();
    issue_cmd(mk_cmd(OP_DRAW, 10, 3, 1'b1, 3, 0));
    issue_cmd(mk_cmd(OP_SCROLL_RIGHT, 0, 0, 1'b0, 1, 0));
    issue_cmd(mk_cmd(OP_READ, 14, 3, 1'b0, 1, 0));
    issue_cmd(mk_cmd(OP_SCROLL_DOWN, 0, 0, 1'b0, 2, 15));
    issue_cmd(mk_cmd(OP_READ, 10, 18, 1'b0, 2, 0));
    issue_cmd(mk_cmd(OP_SCROLL_UP, 0, 0, 1'b0, 3, 15));
    issue_cmd(mk_cmd(OP_SCROLL_LEFT, 0, 0, 1'b0, 0, 0));
    issue_cmd(mk_cmd(OP_SCROLL_LEFT, 0, 0, 1'b0, 3, 0));
    issue_cmd(mk_cmd(OP_READ, 6, 3, 1'b0, 2, 0));
    issue_cmd(mk_cmd(OP_BLANK, 0, 0, 1'b0, 1, 0));
  endtask

  // Extended mode reaches the far corner of the physical screen.
  task automatic test_extended_mode();
    settle_idle();
    write_mode(1'b1);
    issue_cmd(mk_cmd(OP_DRAW, 127, 63, 1'b1, 3, 0));
    issue_cmd(mk_cmd(OP_READ, 127, 63, 1'b0, 3, 0));
    issue_cmd(mk_cmd(OP_SCROLL_DOWN, 0, 0, 1'b0, 3, 0));
    issue_cmd(mk_cmd(OP_READ, 127, 63, 1'b0, 2, 0));
    issue_cmd(mk_cmd(OP_BLANK, 0, 0, 1'b0, 3, 0));
  endtask

  // Random commands in phases that alternate the mode.
  task automatic test_random_mix();
    int phase;
    int n;
    for (phase = 0; phase < PHASES; phase++) begin
      settle_idle();
      write_mode(phase % 2 == 0);
      recent_spots.delete();
      for (n = 0; n < PHASE_ITEMS; n++) begin
        if (n % 50 == 0) gapless = ($urandom_range(0, 3) == 0);
        issue_cmd(random_cmd());
      end
    end
    gapless = 1'b0;
  endtask

  // Compare each result transaction with the oldest owed value.
  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni && res_valid_o) begin
      if (pending_pixels.size() == 0) begin
        flag_error("result transaction with no command outstanding");
      end else begin
        want = pending_pixels.pop_front();
        results_seen++;
        if (res_o.pixel_on !== want.pixel_on) begin
          flag_error($sformatf("result %0d: pixel_on %b, expected %b",
                               results_seen, res_o.pixel_on, want.pixel_on));
        end
        if (res_o.plane_bits !== want.plane_bits) begin
          flag_error($sformatf("result %0d: plane_bits %b, expected %b",
                               results_seen, res_o.plane_bits, want.plane_bits));
        end
      end
    end
  end

  // End the run if no transaction of any kind completes for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start && !busy) || res_valid_o || (psel && penable && pready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
      if (stall_cycles >= STALL_LIMIT) begin
        $display("Watchdog: no transaction for %0d cycles", STALL_LIMIT);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin
    int x;
    int y;
    start   <= 1'b0;
    cmd_i   <= '0;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    rst_ni  <= 1'b0;
    gapless = 1'b0;
    shadow_ext = 1'b0;
    for (y = 0; y < PH; y++) begin
      for (x = 0; x < PW; x++) begin
        shadow_fb[y][x] = '0;
      end
    end
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    write_mode(1'b0);

    test_pixel_ops();
    test_sweeps();
    test_extended_mode();
    test_random_mix();

    settle_idle();
    repeat (16) @(posedge clk_i);
    $display("Covered %0d commands: %0d draws, %0d reads, %0d plane sweeps, %0d mode writes.",
             cmds_sent, draw_count, read_count, sweep_count, mode_writes);
    $display("Compared %0d results and found %0d mismatches.", results_seen, err_count);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
